// ----- hw/rtl/assert_macros.svh -----
// concurrent assertion helpers, clocked on aclk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FSA_ASSERT(lbl, prop, msg)
`define FSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/fsa_pkg.sv -----
`timescale 1ns / 1ps
package fsa_pkg;

    localparam int MAX_PIXELS_DEF  = 16384;
    localparam int NUM_OUTPUTS_DEF = 4;
    localparam int CHANNELS_DEF    = 3;

    localparam int FLT_W = 32;

    typedef enum logic [1:0] {
        CFG_FILM_WIDTH  = 2'd0,
        CFG_FILM_HEIGHT = 2'd1,
        CFG_ENABLE_MASK = 2'd2,
        CFG_TRIPLE_MASK = 2'd3
    } fsa_cfg_idx_t;

    typedef enum logic {
        OP_SPLAT = 1'b0,
        OP_READ  = 1'b1
    } fsa_op_t;

    localparam logic [31:0] FLT_QNAN = 32'h7FC0_0000;

    // store port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } fsa_mem_ctl_t;

    function automatic logic flt_finite(input logic [31:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    // floor of a coordinate: {ok, value}; ok only for values in [0, 256)
    function automatic logic [8:0] floor_coord(input logic [31:0] b);
        logic [7:0]  e;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [8:0]  r;
        e  = b[30:23];
        m  = {1'b1, b[22:0]};
        sh = 5'(8'd150 - e);
        r  = 9'd0;
        if (e == 8'hFF) begin
            r = 9'd0;
        end else if (b[31]) begin
            r = {(b[30:0] == 31'd0), 8'd0};
        end else if (e < 8'd127) begin
            r = {1'b1, 8'd0};
        end else if (e >= 8'd135) begin
            r = 9'd0;
        end else begin
            r = {1'b1, 8'(m >> sh)};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/film_splat_accumulator.sv -----
`timescale 1ns / 1ps
// splat: decode, store read, operand load and float add, then store write-back; a dropped
//   splat returns to idle after decode
// read: decode, store read, operand load, then the result; a result held on
//   m_tready stalls only a later read, one item in the store pipeline at a time
// reset: control and configuration registers cleared, then a zeroing sweep of all
//   NUM_OUTPUTS*MAX_PIXELS rows (65536 at defaults) during which no input transfer is taken
`include "assert_macros.svh"
module film_splat_accumulator #(
    parameter int MAX_PIXELS  = fsa_pkg::MAX_PIXELS_DEF,
    parameter int NUM_OUTPUTS = fsa_pkg::NUM_OUTPUTS_DEF,
    parameter int CHANNELS    = fsa_pkg::CHANNELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // coord_x, coord_y, sample_r, sample_g, sample_b, read_pixel, read_channel
    input  logic [175:0] s_tdata,
    // op, output_sel
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_sum
    output logic [31:0]  m_tdata,
    // read_output
    output logic [1:0]   m_tuser,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    import fsa_pkg::*;

    localparam int DEPTH  = NUM_OUTPUTS * MAX_PIXELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = CHANNELS * FLT_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_FETCH, ST_LOAD, ST_ADD, ST_RESP
    } state_t;

    // configuration
    logic [7:0] film_width_reg, film_height_reg;
    logic [3:0] enable_mask_reg, triple_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            film_width_reg  <= '0;
            film_height_reg <= '0;
            enable_mask_reg <= '0;
            triple_mask_reg <= '0;
        end else if (cfg_valid) begin
            case (fsa_cfg_idx_t'(cfg_index))
                CFG_FILM_WIDTH:  film_width_reg  <= cfg_data;
                CFG_FILM_HEIGHT: film_height_reg <= cfg_data;
                CFG_ENABLE_MASK: enable_mask_reg <= cfg_data[3:0];
                CFG_TRIPLE_MASK: triple_mask_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // item captured on transfer
    state_t      state_reg, state_next;
    logic        op_reg;
    logic [1:0]  sel_reg;
    logic [31:0] cx_reg, cy_reg, smp_r_reg, smp_g_reg, smp_b_reg;
    logic [13:0] rpix_reg;
    logic [1:0]  rch_reg;
    logic        triple_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] resp_reg, resp_next;
    // result held for the output transfer, apart from the working item
    logic [31:0] out_data_reg;
    logic [1:0]  out_sel_reg;

    logic        store_busy;
    logic [DATA_W-1:0] rd_row, wr_row;
    fsa_mem_ctl_t mem_ctl;
    logic        add_start;
    logic [CHANNELS-1:0] add_done;

    // decode
    logic [8:0]  fx, fy;
    logic [15:0] pix;
    logic        sel_ok, splat_ok, read_ok;
    logic [15:0] pix_sel;

    always_comb begin
        fx      = floor_coord(cx_reg);
        fy      = floor_coord(cy_reg);
        pix     = 16'(fy[7:0]) * 16'(film_width_reg) + 16'(fx[7:0]);
        sel_ok  = 32'(sel_reg) < NUM_OUTPUTS;
        splat_ok = sel_ok && enable_mask_reg[sel_reg] && fx[8] && fy[8]
                && (fx[7:0] < film_width_reg) && (fy[7:0] < film_height_reg)
                && (32'(pix) < MAX_PIXELS) && flt_finite(smp_r_reg)
                && (!triple_mask_reg[sel_reg]
                    || (flt_finite(smp_g_reg) && flt_finite(smp_b_reg)));
        read_ok = sel_ok && (32'(rpix_reg) < MAX_PIXELS) && (32'(rch_reg) < CHANNELS);
        pix_sel = (fsa_op_t'(op_reg) == OP_READ) ? 16'(rpix_reg) : pix;
        addr_next = ADDR_W'(32'(sel_reg) * 32'(MAX_PIXELS) + 32'(pix_sel));
    end

    // channel lanes
    logic [31:0] old_lane [CHANNELS];
    logic [31:0] new_lane [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        logic [31:0] smp;
        logic        used;
        assign smp  = (c == 0) ? smp_r_reg : (c == 1) ? smp_g_reg
                    : (c == 2) ? smp_b_reg : 32'd0;
        assign used = (c == 0) || ((c < 3) && triple_reg);
        assign old_lane[c] = rd_row[c*FLT_W +: FLT_W];

        fsa_fadd u_fadd (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (add_start),
            .acc       (old_lane[c]),
            .smp       (smp),
            .out_valid (add_done[c]),
            .sum       (new_lane[c])
        );

        assign wr_row[c*FLT_W +: FLT_W] = used ? new_lane[c] : old_lane[c];
    end

    fsa_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .addr    (addr_reg),
        .wr_data (wr_row),
        .rd_data (rd_row),
        .busy    (store_busy)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        resp_next     = resp_reg;
        mem_ctl       = '0;
        add_start     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !store_busy)
                    state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (fsa_op_t'(op_reg) == OP_READ) begin
                    if (read_ok) begin
                        state_next = ST_FETCH;
                    end else begin
                        resp_next  = 32'd0;
                        state_next = ST_RESP;
                    end
                end else begin
                    state_next = splat_ok ? ST_FETCH : ST_IDLE;
                end
            end
            ST_FETCH: begin
                mem_ctl.rd_en = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                if (fsa_op_t'(op_reg) == OP_READ) begin
                    resp_next  = old_lane[rch_reg[CH_W-1:0]];
                    state_next = ST_RESP;
                end else begin
                    add_start  = 1'b1;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (add_done[0]) begin
                    mem_ctl.wr_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RESP: begin
                // output register free or being drained this cycle
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser[0];
            sel_reg   <= s_tuser[2:1];
            cx_reg    <= s_tdata[31:0];
            cy_reg    <= s_tdata[63:32];
            smp_r_reg <= s_tdata[95:64];
            smp_g_reg <= s_tdata[127:96];
            smp_b_reg <= s_tdata[159:128];
            rpix_reg  <= s_tdata[173:160];
            rch_reg   <= s_tdata[175:174];
        end
        if (state_reg == ST_DECODE) begin
            addr_reg   <= addr_next;
            triple_reg <= triple_mask_reg[sel_reg];
        end
        resp_reg <= resp_next;
        // result moves to the output only when the output register takes it
        if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
            out_data_reg <= resp_reg;
            out_sel_reg  <= sel_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !store_busy;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sel_reg;

    // checks
    `FSA_ASSERT(a_no_take_in_clear, store_busy |-> !s_tready, "input taken during clear sweep")
    `FSA_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second item overlapped")
    `FSA_ASSERT(a_wr_after_add, mem_ctl.wr_en |-> (state_reg == ST_ADD && !store_busy), "stray store write")
    `FSA_ASSERT(a_resp_origin, $rose(m_tvalid) |-> $past(state_reg == ST_RESP), "result without read")

endmodule

// ----- hw/rtl/fsa_fadd.sv -----
`timescale 1ns / 1ps
module fsa_fadd (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [31:0] acc,      // stored sum, may be inf or nan
    input  logic [31:0] smp,      // finite sample
    output logic        out_valid,
    output logic [31:0] sum
);
    import fsa_pkg::*;

    logic [3:0] vld_reg;

    // stage 1: order operands, align
    logic        s1_sign_reg, s1_sub_reg, s1_zsign_reg, s1_spec_reg;
    logic [31:0] s1_spec_val_reg;
    logic [7:0]  s1_exp_reg;
    logic [26:0] s1_mx_reg, s1_my_reg;

    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  e_big, e_sml, d;
    logic [26:0] m_big, m_sml, aligned;
    logic        sticky;

    always_comb begin
        swap    = smp[30:0] > acc[30:0];
        big     = swap ? smp : acc;
        sml     = swap ? acc : smp;
        e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_big   = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        m_sml   = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        d       = e_big - e_sml;
        if (d >= 8'd27) begin
            aligned = 27'd0;
            sticky  = |m_sml;
        end else begin
            aligned = m_sml >> d[4:0];
            sticky  = |(m_sml & ~({27{1'b1}} << d[4:0]));
        end
    end

    // stage 2: add or subtract
    logic        s2_sign_reg, s2_zsign_reg, s2_spec_reg;
    logic [31:0] s2_spec_val_reg;
    logic [7:0]  s2_exp_reg;
    logic [27:0] s2_sum_reg;

    // stage 3: normalize
    logic        s3_sign_reg, s3_zsign_reg, s3_spec_reg, s3_zero_reg;
    logic [31:0] s3_spec_val_reg;
    logic [8:0]  s3_exp_reg;
    logic [26:0] s3_m_reg;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    logic [4:0]  lz;
    logic [7:0]  em1, sh;
    logic [26:0] norm_m;
    logic [8:0]  norm_e;

    always_comb begin
        lz  = lzc27(s2_sum_reg[26:0]);
        em1 = s2_exp_reg - 8'd1;
        sh  = ({3'd0, lz} < em1) ? {3'd0, lz} : em1;
        if (s2_sum_reg[27]) begin
            norm_m = {s2_sum_reg[27:2], s2_sum_reg[1] | s2_sum_reg[0]};
            norm_e = {1'b0, s2_exp_reg} + 9'd1;
        end else begin
            norm_m = s2_sum_reg[26:0] << sh[4:0];
            norm_e = {1'b0, s2_exp_reg} - {1'b0, sh};
        end
    end

    // stage 4: round to nearest even, pack
    logic [31:0] res_reg;
    logic        inc;
    logic [7:0]  field;
    logic [30:0] rounded;
    logic [31:0] res_next;

    always_comb begin
        inc     = s3_m_reg[2] & (s3_m_reg[1] | s3_m_reg[0] | s3_m_reg[3]);
        field   = s3_m_reg[26] ? s3_exp_reg[7:0] : 8'd0;
        rounded = {field, s3_m_reg[25:3]} + 31'(inc);
        if (s3_spec_reg)
            res_next = s3_spec_val_reg;
        else if (s3_zero_reg)
            res_next = {s3_zsign_reg, 31'd0};
        else if (s3_exp_reg >= 9'd255)
            res_next = {s3_sign_reg, 8'hFF, 23'd0};
        else
            res_next = {s3_sign_reg, rounded};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
        s1_sign_reg     <= big[31];
        s1_sub_reg      <= acc[31] ^ smp[31];
        s1_zsign_reg    <= acc[31] & smp[31];
        s1_spec_reg     <= (acc[30:23] == 8'hFF);
        s1_spec_val_reg <= (acc[22:0] != 23'd0) ? FLT_QNAN : acc;
        s1_exp_reg      <= e_big;
        s1_mx_reg       <= m_big;
        s1_my_reg       <= {aligned[26:1], aligned[0] | sticky};

        s2_sign_reg     <= s1_sign_reg;
        s2_zsign_reg    <= s1_zsign_reg;
        s2_spec_reg     <= s1_spec_reg;
        s2_spec_val_reg <= s1_spec_val_reg;
        s2_exp_reg      <= s1_exp_reg;
        s2_sum_reg      <= s1_sub_reg ? ({1'b0, s1_mx_reg} - {1'b0, s1_my_reg})
                                      : ({1'b0, s1_mx_reg} + {1'b0, s1_my_reg});

        s3_sign_reg     <= s2_sign_reg;
        s3_zsign_reg    <= s2_zsign_reg;
        s3_spec_reg     <= s2_spec_reg;
        s3_spec_val_reg <= s2_spec_val_reg;
        s3_zero_reg     <= (s2_sum_reg == 28'd0);
        s3_exp_reg      <= norm_e;
        s3_m_reg        <= norm_m;

        res_reg         <= res_next;
    end

    assign out_valid = vld_reg[3];
    assign sum       = res_reg;

endmodule

// ----- hw/rtl/fsa_store.sv -----
`timescale 1ns / 1ps
module fsa_store #(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1,
    parameter int DATA_W = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fsa_pkg::fsa_mem_ctl_t     ctl,
    input  logic [ADDR_W-1:0]         addr,
    input  logic [DATA_W-1:0]         wr_data,
    output logic [DATA_W-1:0]         rd_data,
    output logic                      busy
);
    import fsa_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              busy_reg;

    // zeroing sweep after reset, one row per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + ADDR_W'(1);
            if (clr_reg == ADDR_W'(DEPTH - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg)
            mem[clr_reg] <= '0;
        else if (ctl.wr_en)
            mem[addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
